// ----- sv/assert_macros.svh -----
// Concurrent assertion helpers; bodies vanish for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/lrai_pkg.sv -----
package lrai_pkg;

    localparam int LED_COUNT_DEF = 24;
    localparam int ADDR_W        = 4;

    typedef logic [23:0] t_rgb;

    localparam t_rgb COL_OLIVE  = 24'h556B2F;
    localparam t_rgb COL_YELLOW = 24'hFFFF00;
    localparam t_rgb COL_RED    = 24'hFF0000;
    localparam t_rgb COL_WHITE  = 24'hFAEBD7;
    localparam t_rgb COL_DBLUE  = 24'h00008B;
    localparam t_rgb COL_SKY    = 24'h87CEEB;
    localparam t_rgb COL_GREEN  = 24'h008000;
    localparam t_rgb COL_DRED   = 24'h8B0000;
    localparam t_rgb COL_GREY   = 24'hA9A9A9;

    localparam logic [7:0] BRIGHT_RST  = 8'd255;
    localparam logic [7:0] BRIGHT_TZ   = 8'd50;
    localparam logic [7:0] BRIGHT_NONE = 8'd5;

    localparam logic [4:0]  CLOCK_OFFSET_RST = 5'd0;
    localparam logic [15:0] PERIOD_RST       = 16'd50;
    localparam logic [5:0]  INVERT_RST       = 6'd0;

    // register index = paddr[3:2]
    localparam logic [1:0] REG_CLOCK_OFFSET = 2'd0;
    localparam logic [1:0] REG_UPDATE_PERIOD = 2'd1;
    localparam logic [1:0] REG_AXIS_INVERT  = 2'd2;

    localparam logic [2:0] AXIS_TX = 3'd0;
    localparam logic [2:0] AXIS_TY = 3'd1;
    localparam logic [2:0] AXIS_TZ = 3'd2;
    localparam logic [2:0] AXIS_RX = 3'd3;
    localparam logic [2:0] AXIS_RY = 3'd4;
    localparam logic [2:0] AXIS_RZ = 3'd5;

    typedef struct packed {
        logic [4:0]  clock_offset;
        logic [15:0] update_period_ms;
        logic [5:0]  axis_invert_mask;
    } t_cfg;

    // one ring frame: background color, optional marker color, brightness
    typedef struct packed {
        t_rgb       base;
        t_rgb       mark;
        logic       mark_en;
        logic [7:0] bright;
    } t_frame;

endpackage

// ----- sv/led_ring_axis_indicator.sv -----
// A tick that starts a frame passes the pending, current-frame and output registers to
// its first LED word, then one word per cycle while the output is not stalled.
// Throughput: one tick per cycle, except while a frame sits in the pending register:
// that is the cycle after a frame-starting tick, longer while an earlier frame streams.
// Reset (synchronous, active low): registers to defaults, elapsed and rotation zero,
// brightness 255, no frame pending or streaming.
`include "assert_macros.svh"

module led_ring_axis_indicator #(
    parameter  int LED_COUNT = lrai_pkg::LED_COUNT_DEF,
    localparam int W         = $clog2(LED_COUNT)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lrai_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_led_on_request,
    input  logic [2:0]                   i_main_axis,
    input  logic                         i_main_positive,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [W-1:0]                 o_led_index,
    output logic [7:0]                   o_red,
    output logic [7:0]                   o_green,
    output logic [7:0]                   o_blue,
    output logic [7:0]                   o_brightness,
    output logic                         o_last_led
);

    localparam logic [W-1:0] LAST_IDX = W'(LED_COUNT - 1);

    lrai_pkg::t_cfg    cfg;
    lrai_pkg::t_frame  frame;
    logic [3:0][W-1:0] pos;
    logic              frame_wr;
    logic              in_accept;

    assign in_accept = i_in_valid && !o_in_stall;

    lrai_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lrai_tick #(
        .LED_COUNT (LED_COUNT)
    ) u_tick (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_led_on_request (i_led_on_request),
        .i_main_axis      (i_main_axis),
        .i_main_positive  (i_main_positive),
        .i_cfg            (cfg),
        .o_frame_wr       (frame_wr),
        .o_frame          (frame),
        .o_pos            (pos)
    );

    lrai_stream #(
        .LED_COUNT (LED_COUNT)
    ) u_stream (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_frame_wr   (frame_wr),
        .i_frame      (frame),
        .i_pos        (pos),
        .o_full       (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_led_index  (o_led_index),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_brightness (o_brightness),
        .o_last_led   (o_last_led)
    );

    // a frame streams without gaps, in index order, at one brightness
    `ASSERT_NEXT(a_idx_step, i_clk, i_rst_n,
                 o_out_valid && !i_out_stall && !o_last_led,
                 o_out_valid && (o_led_index == $past(o_led_index) + W'(1)),
                 "frame word out of order")
    `ASSERT_NEXT(a_bright_hold, i_clk, i_rst_n,
                 o_out_valid && !i_out_stall && !o_last_led,
                 o_brightness == $past(o_brightness),
                 "brightness changed inside a frame")
    `ASSERT_IMPL(a_last_flag, i_clk, i_rst_n,
                 o_out_valid, o_last_led == (o_led_index == LAST_IDX),
                 "last flag does not match index")

endmodule

// ----- sv/lrai_cfg.sv -----
module lrai_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lrai_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output lrai_pkg::t_cfg                o_cfg
);

    logic [4:0]  r_clock_offset;
    logic [15:0] r_update_period;
    logic [5:0]  r_axis_invert;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_offset  <= lrai_pkg::CLOCK_OFFSET_RST;
            r_update_period <= lrai_pkg::PERIOD_RST;
            r_axis_invert   <= lrai_pkg::INVERT_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                lrai_pkg::REG_CLOCK_OFFSET:  r_clock_offset  <= pwdata[4:0];
                lrai_pkg::REG_UPDATE_PERIOD: r_update_period <= pwdata[15:0];
                lrai_pkg::REG_AXIS_INVERT:   r_axis_invert   <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lrai_pkg::REG_CLOCK_OFFSET:  prdata = 32'(r_clock_offset);
            lrai_pkg::REG_UPDATE_PERIOD: prdata = 32'(r_update_period);
            lrai_pkg::REG_AXIS_INVERT:   prdata = 32'(r_axis_invert);
            default:                     prdata = '0;
        endcase
    end

    assign o_cfg.clock_offset     = r_clock_offset;
    assign o_cfg.update_period_ms = r_update_period;
    assign o_cfg.axis_invert_mask = r_axis_invert;

endmodule

// ----- sv/lrai_tick.sv -----
module lrai_tick #(
    parameter  int LED_COUNT = lrai_pkg::LED_COUNT_DEF,
    localparam int W         = $clog2(LED_COUNT)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_led_on_request,
    input  logic [2:0]             i_main_axis,
    input  logic                   i_main_positive,
    input  lrai_pkg::t_cfg         i_cfg,
    output logic                   o_frame_wr,
    output lrai_pkg::t_frame       o_frame,
    output logic [3:0][W-1:0]      o_pos
);

    localparam int SW   = W + 1;
    localparam int STEP = LED_COUNT / 12;
    localparam logic [W-1:0] HOUR3  = W'((3 * STEP) % LED_COUNT);
    localparam logic [W-1:0] HOUR6  = W'((6 * STEP) % LED_COUNT);
    localparam logic [W-1:0] HOUR9  = W'((9 * STEP) % LED_COUNT);
    localparam logic [W-1:0] HOUR12 = W'((12 * STEP) % LED_COUNT);
    localparam logic [W-1:0] LAST   = W'(LED_COUNT - 1);
    localparam logic [SW-1:0] N     = SW'(LED_COUNT);

    logic [15:0]   r_elapsed, n_elapsed;
    logic [W-1:0]  r_rotate, n_rotate;
    logic [7:0]    r_bright, n_bright;

    logic          emit;
    logic [15:0]   remain;
    logic          flip;
    logic [7:0]    inv_ext;
    logic [W-1:0]  hour_pos;
    logic          use_rot;
    logic [SW-1:0] off0, off1, off_mod, p_sum, p;
    logic [SW-1:0] p_next, p_prev, p_prev2;

    assign emit   = r_elapsed >= i_cfg.update_period_ms;
    assign remain = emit ? r_elapsed - i_cfg.update_period_ms : r_elapsed;

    assign inv_ext = {2'b00, i_cfg.axis_invert_mask};
    assign flip    = (i_main_axis <= lrai_pkg::AXIS_RZ) &&
                     (i_main_positive != inv_ext[i_main_axis]);

    // clock position of the marker group, offset folded into the ring
    always_comb begin
        off0    = SW'(i_cfg.clock_offset);
        off1    = (off0 >= N) ? off0 - N : off0;
        off_mod = (off1 >= N) ? off1 - N : off1;
        p_sum   = off_mod + SW'(hour_pos);
        p       = (p_sum >= N) ? p_sum - N : p_sum;
        p_next  = (p == N - SW'(1)) ? '0 : p + SW'(1);
        p_prev  = (p == '0) ? N - SW'(1) : p - SW'(1);
        p_prev2 = (p >= SW'(2)) ? p - SW'(2) : p + N - SW'(2);
    end

    always_comb begin
        o_frame.base    = lrai_pkg::COL_GREY;
        o_frame.mark    = lrai_pkg::COL_GREY;
        o_frame.mark_en = 1'b0;
        hour_pos        = HOUR3;
        use_rot         = 1'b0;
        n_bright        = r_bright;
        n_rotate        = r_rotate;
        if (i_led_on_request) begin
            o_frame.base = lrai_pkg::COL_OLIVE;
        end else begin
            case (i_main_axis)
                lrai_pkg::AXIS_TX: begin
                    o_frame.base    = lrai_pkg::COL_YELLOW;
                    o_frame.mark    = lrai_pkg::COL_RED;
                    o_frame.mark_en = 1'b1;
                    hour_pos        = flip ? HOUR9 : HOUR3;
                end
                lrai_pkg::AXIS_TY: begin
                    o_frame.base    = lrai_pkg::COL_YELLOW;
                    o_frame.mark    = lrai_pkg::COL_RED;
                    o_frame.mark_en = 1'b1;
                    hour_pos        = flip ? HOUR6 : HOUR12;
                end
                lrai_pkg::AXIS_TZ: begin
                    o_frame.base = flip ? lrai_pkg::COL_WHITE : lrai_pkg::COL_DBLUE;
                    n_bright     = lrai_pkg::BRIGHT_TZ;
                end
                lrai_pkg::AXIS_RX: begin
                    o_frame.base    = lrai_pkg::COL_SKY;
                    o_frame.mark    = lrai_pkg::COL_GREEN;
                    o_frame.mark_en = 1'b1;
                    hour_pos        = flip ? HOUR12 : HOUR6;
                end
                lrai_pkg::AXIS_RY: begin
                    o_frame.base    = lrai_pkg::COL_SKY;
                    o_frame.mark    = lrai_pkg::COL_GREEN;
                    o_frame.mark_en = 1'b1;
                    hour_pos        = flip ? HOUR9 : HOUR3;
                end
                lrai_pkg::AXIS_RZ: begin
                    o_frame.base    = lrai_pkg::COL_SKY;
                    o_frame.mark    = lrai_pkg::COL_DRED;
                    o_frame.mark_en = 1'b1;
                    use_rot         = 1'b1;
                    if (flip) begin
                        n_rotate = (r_rotate == '0) ? LAST : r_rotate - W'(1);
                    end else begin
                        n_rotate = (r_rotate == LAST) ? '0 : r_rotate + W'(1);
                    end
                end
                default: begin
                    n_bright = lrai_pkg::BRIGHT_NONE;
                end
            endcase
        end
        o_frame.bright = n_bright;
    end

    always_comb begin
        if (use_rot) begin
            o_pos = {4{r_rotate}};
        end else begin
            o_pos = {p_prev2[W-1:0], p_prev[W-1:0], p_next[W-1:0], p[W-1:0]};
        end
    end

    assign n_elapsed  = (remain != 16'hFFFF) ? remain + 16'd1 : remain;
    assign o_frame_wr = i_accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_rotate  <= '0;
            r_bright  <= lrai_pkg::BRIGHT_RST;
        end else if (i_accept) begin
            r_elapsed <= n_elapsed;
            if (emit) begin
                r_rotate <= n_rotate;
                r_bright <= n_bright;
            end
        end
    end

endmodule

// ----- sv/lrai_stream.sv -----
module lrai_stream #(
    parameter  int LED_COUNT = lrai_pkg::LED_COUNT_DEF,
    localparam int W         = $clog2(LED_COUNT)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_frame_wr,
    input  lrai_pkg::t_frame       i_frame,
    input  logic [3:0][W-1:0]      i_pos,
    output logic                   o_full,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [W-1:0]           o_led_index,
    output logic [7:0]             o_red,
    output logic [7:0]             o_green,
    output logic [7:0]             o_blue,
    output logic [7:0]             o_brightness,
    output logic                   o_last_led
);

    localparam logic [W-1:0] LAST = W'(LED_COUNT - 1);

    // one frame waiting, one frame streaming
    logic                 r_pend_valid;
    lrai_pkg::t_frame     r_pend;
    logic [3:0][W-1:0]    r_pend_pos;
    logic                 r_busy;
    lrai_pkg::t_frame     r_cur;
    logic [3:0][W-1:0]    r_cur_pos;
    logic [W-1:0]         r_idx;

    logic                 r_out_valid;
    logic [W-1:0]         r_out_idx;
    lrai_pkg::t_rgb       r_out_rgb;
    logic [7:0]           r_out_bright;
    logic                 r_out_last;

    logic                 out_free;
    logic                 cur_done;
    logic                 cur_free;
    logic                 hit;
    lrai_pkg::t_rgb       led_rgb;

    assign out_free = !r_out_valid || !i_out_stall;
    assign cur_done = r_busy && out_free && (r_idx == LAST);
    assign cur_free = !r_busy || cur_done;

    assign hit = r_cur.mark_en &&
                 (r_idx == r_cur_pos[0] || r_idx == r_cur_pos[1] ||
                  r_idx == r_cur_pos[2] || r_idx == r_cur_pos[3]);
    assign led_rgb = hit ? r_cur.mark : r_cur.base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_busy       <= 1'b0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_frame_wr) begin
                r_pend_valid <= 1'b1;
            end else if (cur_free && r_pend_valid) begin
                r_pend_valid <= 1'b0;
            end

            if (cur_free && r_pend_valid) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (cur_done) begin
                r_busy <= 1'b0;
            end else if (r_busy && out_free) begin
                r_idx <= r_idx + W'(1);
            end

            if (out_free) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame_wr) begin
            r_pend     <= i_frame;
            r_pend_pos <= i_pos;
        end
        if (cur_free && r_pend_valid) begin
            r_cur     <= r_pend;
            r_cur_pos <= r_pend_pos;
        end
        if (out_free && r_busy) begin
            r_out_idx    <= r_idx;
            r_out_rgb    <= led_rgb;
            r_out_bright <= r_cur.bright;
            r_out_last   <= (r_idx == LAST);
        end
    end

    assign o_full       = r_pend_valid;
    assign o_out_valid  = r_out_valid;
    assign o_led_index  = r_out_idx;
    assign o_red        = r_out_rgb[23:16];
    assign o_green      = r_out_rgb[15:8];
    assign o_blue       = r_out_rgb[7:0];
    assign o_brightness = r_out_bright;
    assign o_last_led   = r_out_last;

endmodule

// ----- tb/tb_led_ring_axis_indicator.sv -----
`timescale 1ns / 1ps

module tb_led_ring_axis_indicator;

    localparam int RING_LEDS = lrai_pkg::LED_COUNT_DEF;
    localparam logic [2:0] AXIS_NONE  = 3'd6;
    localparam logic [2:0] AXIS_SPARE = 3'd7;

    typedef struct packed {
        logic [4:0] led_idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] bright;
        logic       last;
    } t_led_word;

    // Tracks ring state and config; turns each accepted tick into the frame words it causes.
    class ring_predictor;
        logic [4:0]     clock_offset;
        logic [15:0]    period;
        logic [5:0]     invert_mask;
        logic [15:0]    elapsed_ms;
        logic [4:0]     rotate_pos;
        logic [7:0]     bright;
        lrai_pkg::t_rgb ring [RING_LEDS];
        t_led_word      expected_leds [$];
        int             errors;

        function new();
            errors = 0;
            reset_state();
        endfunction

        function void reset_state();
            clock_offset = lrai_pkg::CLOCK_OFFSET_RST;
            period       = lrai_pkg::PERIOD_RST;
            invert_mask  = lrai_pkg::INVERT_RST;
            elapsed_ms   = '0;
            rotate_pos   = '0;
            bright       = lrai_pkg::BRIGHT_RST;
            expected_leds.delete();
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                lrai_pkg::REG_CLOCK_OFFSET:  clock_offset = value[4:0];
                lrai_pkg::REG_UPDATE_PERIOD: period       = value[15:0];
                lrai_pkg::REG_AXIS_INVERT:   invert_mask  = value[5:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                lrai_pkg::REG_CLOCK_OFFSET:  return {27'd0, clock_offset};
                lrai_pkg::REG_UPDATE_PERIOD: return {16'd0, period};
                lrai_pkg::REG_AXIS_INVERT:   return {26'd0, invert_mask};
                default:                     return '0;
            endcase
        endfunction

        function void fill_ring(lrai_pkg::t_rgb c);
            foreach (ring[i]) ring[i] = c;
        endfunction

        // four LEDs around a clock hour: p, p+1, p-1, p-2
        function void place_four(int hour, lrai_pkg::t_rgb c);
            int p;
            p = (int'(clock_offset) + (hour * (RING_LEDS / 12)) % RING_LEDS) % RING_LEDS;
            ring[p] = c;
            ring[(p + 1) % RING_LEDS] = c;
            ring[(p + RING_LEDS - 1) % RING_LEDS] = c;
            ring[(p + RING_LEDS - 2) % RING_LEDS] = c;
        endfunction

        function void note_tick(logic req, logic [2:0] axis, logic pos);
            logic      emit;
            logic      flip;
            t_led_word w;
            emit = (elapsed_ms >= period);
            if (emit) elapsed_ms = elapsed_ms - period;
            if (elapsed_ms != 16'hFFFF) elapsed_ms = elapsed_ms + 16'd1;
            if (!emit) return;
            flip = (axis < AXIS_NONE) ? (pos ^ invert_mask[axis]) : 1'b0;
            if (req) begin
                fill_ring(lrai_pkg::COL_OLIVE);
            end else begin
                case (axis)
                    lrai_pkg::AXIS_TX: begin
                        fill_ring(lrai_pkg::COL_YELLOW);
                        place_four(flip ? 9 : 3, lrai_pkg::COL_RED);
                    end
                    lrai_pkg::AXIS_TY: begin
                        fill_ring(lrai_pkg::COL_YELLOW);
                        place_four(flip ? 6 : 12, lrai_pkg::COL_RED);
                    end
                    lrai_pkg::AXIS_TZ: begin
                        fill_ring(flip ? lrai_pkg::COL_WHITE : lrai_pkg::COL_DBLUE);
                        bright = lrai_pkg::BRIGHT_TZ;
                    end
                    lrai_pkg::AXIS_RX: begin
                        fill_ring(lrai_pkg::COL_SKY);
                        place_four(flip ? 12 : 6, lrai_pkg::COL_GREEN);
                    end
                    lrai_pkg::AXIS_RY: begin
                        fill_ring(lrai_pkg::COL_SKY);
                        place_four(flip ? 9 : 3, lrai_pkg::COL_GREEN);
                    end
                    lrai_pkg::AXIS_RZ: begin
                        fill_ring(lrai_pkg::COL_SKY);
                        ring[rotate_pos] = lrai_pkg::COL_DRED;
                        if (flip)
                            rotate_pos = (rotate_pos == 0) ? 5'(RING_LEDS - 1) : rotate_pos - 5'd1;
                        else
                            rotate_pos = (rotate_pos == RING_LEDS - 1) ? 5'd0 : rotate_pos + 5'd1;
                    end
                    default: begin
                        fill_ring(lrai_pkg::COL_GREY);
                        bright = lrai_pkg::BRIGHT_NONE;
                    end
                endcase
            end
            for (int i = 0; i < RING_LEDS; i++) begin
                w.led_idx = 5'(i);
                w.red     = ring[i][23:16];
                w.green   = ring[i][15:8];
                w.blue    = ring[i][7:0];
                w.bright  = bright;
                w.last    = (i == RING_LEDS - 1);
                expected_leds.push_back(w);
            end
        endfunction

        function void check_field(string what, int exp_v, int got_v);
            if (exp_v != got_v) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, what, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_led(t_led_word got);
            t_led_word want;
            if (expected_leds.size() == 0) begin
                $display("%0t: unexpected LED word, expected none, actual index %0d",
                         $time, got.led_idx);
                errors++;
                return;
            end
            want = expected_leds.pop_front();
            check_field("led_index", int'(want.led_idx), int'(got.led_idx));
            check_field("red", int'(want.red), int'(got.red));
            check_field("green", int'(want.green), int'(got.green));
            check_field("blue", int'(want.blue), int'(got.blue));
            check_field("brightness", int'(want.bright), int'(got.bright));
            check_field("last_led", int'(want.last), int'(got.last));
        endfunction

        function int pending();
            return expected_leds.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_led_on_request;
    logic [2:0]  i_main_axis;
    logic        i_main_positive;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [4:0]  o_led_index;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic [7:0]  o_brightness;
    logic        o_last_led;

    ring_predictor pred;
    bit            calm;
    int            stall_left;

    led_ring_axis_indicator u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_led_on_request (i_led_on_request),
        .i_main_axis      (i_main_axis),
        .i_main_positive  (i_main_positive),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_led_index      (o_led_index),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_brightness     (o_brightness),
        .o_last_led       (o_last_led)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stall bursts, none while calm
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 8);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            pred.check_led({o_led_index, o_red, o_green, o_blue, o_brightness, o_last_led});
    end

    task automatic apb_read_check(logic [1:0] idx);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== pred.reg_value(idx)) begin
            $display("%0t: register %0d readback mismatch, expected 0x%0h, actual 0x%0h",
                     $time, idx, pred.reg_value(idx), prdata);
            pred.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pred.write_reg(idx, value);
        apb_read_check(idx);
    endtask

    task automatic set_ring_config(logic [4:0] offset, logic [15:0] period, logic [5:0] mask);
        apb_write(lrai_pkg::REG_CLOCK_OFFSET, {27'd0, offset});
        apb_write(lrai_pkg::REG_UPDATE_PERIOD, {16'd0, period});
        apb_write(lrai_pkg::REG_AXIS_INVERT, {26'd0, mask});
    endtask

    task automatic send_tick(logic req, logic [2:0] axis, logic pos);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_led_on_request <= req;
        i_main_axis      <= axis;
        i_main_positive  <= pos;
        do @(posedge i_clk); while (o_in_stall);
        pred.note_tick(req, axis, pos);
    endtask

    task automatic send_random_tick();
        logic [2:0] axis;
        axis = ($urandom_range(0, 3) == 0) ? lrai_pkg::AXIS_RZ : 3'($urandom_range(0, 7));
        send_tick($urandom_range(0, 7) == 0, axis, 1'($urandom_range(0, 1)));
    endtask

    // a tick with no frame may still be in flight when the queue empties
    task automatic drain_ring();
        i_in_valid <= 1'b0;
        while (pred.pending() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        pred = new();
        calm             = 1'b0;
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        i_in_valid       <= 1'b0;
        i_led_on_request <= 1'b0;
        i_main_axis      <= '0;
        i_main_positive  <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_read_check(lrai_pkg::REG_CLOCK_OFFSET);
        apb_read_check(lrai_pkg::REG_UPDATE_PERIOD);
        apb_read_check(lrai_pkg::REG_AXIS_INVERT);

        // default period: first frame on the tick after the period runs out
        repeat (52) send_random_tick();
        drain_ring();

        // directed: every axis both ways, on request, frame on every tick
        set_ring_config(5'd0, 16'd0, 6'd0);
        send_tick(1'b1, lrai_pkg::AXIS_TX, 1'b0);
        for (int a = 0; a < 8; a++) begin
            send_tick(1'b0, 3'(a), 1'b0);
            send_tick(1'b0, 3'(a), 1'b1);
        end
        drain_ring();
        set_ring_config(5'd23, 16'd0, 6'h3F);
        send_tick(1'b1, AXIS_SPARE, 1'b1);
        for (int a = 0; a < 6; a++)
            send_tick(1'b0, 3'(a), 1'b1);
        drain_ring();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_ring_config(5'd31, 16'hFFFF, 6'h3F);
                1: set_ring_config(5'd23, 16'd1, 6'd0);
                2: set_ring_config(5'd24, 16'd0, 6'($urandom_range(0, 63)));
                3: set_ring_config(5'($urandom_range(0, 31)), 16'd1000,
                                   6'($urandom_range(0, 63)));
                default: set_ring_config(5'($urandom_range(0, 31)),
                                         16'($urandom_range(0, 3)),
                                         6'($urandom_range(0, 63)));
            endcase
            if (ph == 5) calm = 1'b1;
            for (int n = 0; n < 16; n++) begin
                if (ph == 4 && n == 8) begin
                    // hold the sender until the ring is empty
                    i_in_valid <= 1'b0;
                    while (pred.pending() > 0) @(posedge i_clk);
                end else begin
                    send_random_tick();
                end
            end
            drain_ring();
        end

        repeat (20) @(posedge i_clk);
        if (pred.errors == 0 && pred.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
